// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cache lookup design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SLRU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SLRU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/slru_pkg.sv -----
// ----------------------------------------------------------------------------
// slru_pkg
// Beat types, register indexes and state codes of the cache lookup block.
// ----------------------------------------------------------------------------
package slru_pkg;

   // Width of a stored tag.
   localparam int TAG_W = 63;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_SET_INDEX_BITS = 2'd0;
   localparam logic [1:0] CSR_OFFSET_BITS    = 2'd1;
   localparam logic [1:0] CSR_WAYS_IN_USE    = 2'd2;

   // One request beat.
   typedef struct packed {
      logic [63:0] address;
      logic        func;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic        hit;
      logic        miss;
      logic        evicted;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] evict_count;
      logic        last_result;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_FIRST  = 4'b0100,
      ST_SECOND = 4'b1000
   } state_type;

endpackage

// ----- design/slru_ram.sv -----
// ----------------------------------------------------------------------------
// slru_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module slru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/set_assoc_lru_cache_lookup_top.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_top
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// A request beat carries an address and a function bit; a plain access gives
// one response beat and a modify gives two, the second marked last_result.
// One set is one RAM row holding every way's valid bit, tag and recency rank.
// After reset the block clears every row in turn, writing empty rows, and holds
// req_ready low until done. A plain access reads the row, then compares and
// writes it back; a modify makes a second access that works on the row just
// written, kept in a register, instead of reading the RAM again. The next
// request is taken while a response still waits; a lookup that finds the
// response register full waits until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_lru_cache_lookup_top
   import slru_pkg::*;
#(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_data
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SET_W    = MAX_SET_BITS;
   localparam int SETB_W   = $clog2(MAX_SET_BITS + 1);
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
   localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int ENTRY_W  = TAG_W + AGE_W + 1;
   localparam int ROW_W    = MAX_WAYS * ENTRY_W;
   localparam logic [AGE_W-1:0] AGE_MAX    = AGE_W'(MAX_WAYS - 1);
   localparam logic [AGE_W:0]   LIMIT_ALL  = (AGE_W + 1)'(MAX_WAYS);
   localparam logic [SET_W-1:0] CLEAR_LAST = SET_W'(NUM_SETS - 1);

   // Configuration registers.
   logic [3:0] set_bits_ff;
   logic [5:0] offset_bits_ff;
   logic [2:0] ways_ff;

   // Sequencer and per-item registers.
   state_type        state_ff, state_in;
   logic [SET_W-1:0] clear_ff;
   logic             func_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [SET_W-1:0] set_ff;
   logic [ROW_W-1:0] row_ff;

   // Totals and response register.
   logic [31:0] hit_total_ff, miss_total_ff, evict_total_ff;
   logic [31:0] hit_total_in, miss_total_in, evict_total_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   // RAM connections.
   logic             ram_wr_en;
   logic [SET_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [ROW_W-1:0] ram_rd_data;
   logic [ROW_W-1:0] row_new;

   // Address split and effective configuration.
   logic [SETB_W-1:0] set_bits_eff;
   logic [5:0]        offset_eff;
   logic [WCNT_W-1:0] ways_eff;
   logic [63:0]       addr_shifted;
   logic [63:0]       addr_tag_full;
   logic [SET_W-1:0]  set_mask;
   logic [SET_W-1:0]  set_idx;

   // Lookup signals.
   logic                accept;
   logic                advance;
   logic                out_free;
   logic                clearing;
   logic [ROW_W-1:0]    row_cur;
   logic [MAX_WAYS-1:0] valid_cur;
   logic [TAG_W-1:0]    tag_w [MAX_WAYS];
   logic [AGE_W-1:0]    age_w [MAX_WAYS];
   logic [AGE_W-1:0]    age_new [MAX_WAYS];
   logic                hit_found;
   logic                free_found;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    free_way;
   logic [WAY_W-1:0]    victim_way;
   logic [WAY_W-1:0]    target_way;
   logic [AGE_W:0]      limit;
   logic                is_evict;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // Clamp the registers into their legal ranges.
   always_comb begin
      if (set_bits_ff == 4'd0) begin
         set_bits_eff = SETB_W'(1);
      end else if (set_bits_ff > MAX_SET_BITS) begin
         set_bits_eff = SETB_W'(MAX_SET_BITS);
      end else begin
         set_bits_eff = SETB_W'(set_bits_ff);
      end
      if (offset_bits_ff == 6'd0) begin
         offset_eff = 6'd1;
      end else if (offset_bits_ff > 6'd32) begin
         offset_eff = 6'd32;
      end else begin
         offset_eff = offset_bits_ff;
      end
      if (ways_ff == 3'd0) begin
         ways_eff = WCNT_W'(1);
      end else if (ways_ff > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ff);
      end
   end

   // Split the request address into set index and tag.
   always_comb begin
      addr_shifted  = req_data.address >> offset_eff;
      addr_tag_full = req_data.address >> (7'(offset_eff) + 7'(set_bits_eff));
      for (int i = 0; i < SET_W; i++) begin
         set_mask[i] = (i < set_bits_eff);
      end
      set_idx = addr_shifted[SET_W-1:0] & set_mask;
   end

   // Handshakes.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = ((state_ff == ST_FIRST) || (state_ff == ST_SECOND)) && out_free;
   assign clearing  = (state_ff == ST_CLEAR);
   assign csr_ready = 1'b1;
   assign ram_rd_en = accept;

   // The clearing pass writes empty rows; otherwise the lookup writes back.
   assign ram_wr_en   = advance || clearing;
   assign ram_wr_addr = clearing ? clear_ff : set_ff;
   assign ram_wr_data = clearing ? '0 : row_new;

   // Set row store.
   slru_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (set_idx),
      .rd_data (ram_rd_data)
   );

   // Unpack the current row; the second access of a modify uses the row just
   // written.
   always_comb begin
      row_cur = (state_ff == ST_SECOND) ? row_ff : ram_rd_data;
      for (int w = 0; w < MAX_WAYS; w++) begin
         tag_w[w]     = row_cur[w*ENTRY_W +: TAG_W];
         age_w[w]     = row_cur[w*ENTRY_W+TAG_W +: AGE_W];
         valid_cur[w] = row_cur[w*ENTRY_W+TAG_W+AGE_W];
      end
   end

   // Hit search, first free way and LRU victim.
   always_comb begin
      hit_found  = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      victim_way = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (!hit_found && (w < ways_eff) && valid_cur[w] && (tag_w[w] == tag_ff)) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
         end
         if (!free_found && (w < ways_eff) && !valid_cur[w]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         if ((w < ways_eff) && (age_w[w] > age_w[victim_way])) begin
            victim_way = WAY_W'(w);
         end
      end
   end

   // Pick the target way and the rank limit below which lines grow older.
   always_comb begin
      is_evict = 1'b0;
      if (hit_found) begin
         target_way = hit_way;
         limit      = {1'b0, age_w[hit_way]};
      end else if (free_found) begin
         target_way = free_way;
         limit      = LIMIT_ALL;
      end else begin
         target_way = victim_way;
         limit      = {1'b0, age_w[victim_way]};
         is_evict   = 1'b1;
      end
   end

   // Build the updated row.
   always_comb begin
      row_new = row_cur;
      for (int w = 0; w < MAX_WAYS; w++) begin
         age_new[w] = age_w[w];
         if (WAY_W'(w) == target_way) begin
            age_new[w] = '0;
         end else if ((w < ways_eff) && ({1'b0, age_w[w]} < limit) &&
                      (age_w[w] < AGE_MAX)) begin
            age_new[w] = age_w[w] + AGE_W'(1);
         end
         row_new[w*ENTRY_W+TAG_W +: AGE_W] = age_new[w];
         if ((WAY_W'(w) == target_way) && !hit_found) begin
            row_new[w*ENTRY_W +: TAG_W]       = tag_ff;
            row_new[w*ENTRY_W+TAG_W+AGE_W]    = 1'b1;
         end
      end
   end

   // Next totals and next state.
   always_comb begin
      hit_total_in   = hit_found ? sat_inc(hit_total_ff) : hit_total_ff;
      miss_total_in  = hit_found ? miss_total_ff : sat_inc(miss_total_ff);
      evict_total_in = is_evict ? sat_inc(evict_total_ff) : evict_total_ff;
      state_in       = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (advance) begin
               state_in = func_ff ? ST_SECOND : ST_IDLE;
            end
         end
         ST_SECOND: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= 4'd1;
         offset_bits_ff <= 6'd4;
         ways_ff        <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SET_INDEX_BITS: set_bits_ff    <= csr_data[3:0];
            CSR_OFFSET_BITS:    offset_bits_ff <= csr_data;
            CSR_WAYS_IN_USE:    ways_ff        <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   // Control state, clearing counter and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clear_ff <= clear_ff + SET_W'(1);
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            hit_total_ff   <= hit_total_in;
            miss_total_ff  <= miss_total_in;
            evict_total_ff <= evict_total_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item registers and response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_data.func;
         tag_ff  <= addr_tag_full[TAG_W-1:0];
         set_ff  <= set_idx;
      end
      if (advance) begin
         row_ff                  <= row_new;
         rsp_data_ff.hit         <= hit_found;
         rsp_data_ff.miss        <= !hit_found;
         rsp_data_ff.evicted     <= is_evict;
         rsp_data_ff.hit_count   <= hit_total_in;
         rsp_data_ff.miss_count  <= miss_total_in;
         rsp_data_ff.evict_count <= evict_total_in;
         rsp_data_ff.last_result <= (state_ff == ST_SECOND) || !func_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer and the response beat.
   `SLRU_ASSERT(a_second_only_modify, clock, reset,
      (state_ff == ST_SECOND) |-> func_ff, "second access without a modify")
   `SLRU_ASSERT(a_modify_goes_second, clock, reset,
      (advance && (state_ff == ST_FIRST) && func_ff) |=> (state_ff == ST_SECOND),
      "modify did not make its second access")
   `SLRU_ASSERT(a_hit_xor_miss, clock, reset,
      rsp_valid_ff |-> (rsp_data_ff.hit != rsp_data_ff.miss), "hit and miss disagree")
   `SLRU_ASSERT(a_evict_is_miss, clock, reset,
      (rsp_valid_ff && rsp_data_ff.evicted) |-> rsp_data_ff.miss, "eviction on a hit")
   `SLRU_ASSERT(a_hold_when_full, clock, reset,
      (rsp_valid_ff && !rsp_ready) |-> !ram_wr_en, "row written while the response is stalled")

endmodule
